// ----- hdl/acps_pkg.sv -----
// Shared types and constants of the adaptive cruise PID step unit.
// Fixed-point formats, register indexes, drive modes, datapath commands.
// No dependencies.
`timescale 1ns / 1ps

package acps_pkg;

   localparam int FRAC_BITS = 16;

   localparam int VAL_W        = 31;
   localparam int DIST_W       = 8;
   localparam int MODE_W       = 3;
   localparam int MARGIN_W     = FRAC_BITS + 5;
   localparam int MARGIN_OUT_W = 20;
   localparam int NUM_W        = DIST_W + 2 * FRAC_BITS;
   localparam int DIV_CNT_W    = $clog2(NUM_W + 1);
   localparam int RAD_W        = 64;
   localparam int ROOT_W       = 32;
   localparam int MUL_A_W      = VAL_W + 2;
   localparam int MUL_B_W      = VAL_W + 2;
   localparam int PROD_W       = MUL_A_W + 1 + MUL_B_W;
   localparam int ACC_W        = PROD_W - FRAC_BITS + 2;
   localparam int T_W          = VAL_W + 3;
   localparam int NV_W         = VAL_W + 3;
   localparam int TDATA_IN_W   = 8;
   localparam int TDATA_OUT_W  = 120;

   localparam longint ONE_Q       = 64'sd1 <<< FRAC_BITS;
   localparam longint HALF_Q      = ONE_Q / 2;
   localparam longint TEN_Q       = 10 * ONE_Q;
   localparam longint HUNDREDTH_Q = (ONE_Q + 50) / 100;
   localparam longint K2_Q        = 2 * ONE_Q;
   localparam longint K27_Q       = (27 * ONE_Q + 5) / 10;
   localparam longint INT32_MAX   = 64'sd2147483647;
   localparam longint INT32_MIN   = -64'sd2147483648;

   localparam int NO_ECHO_DIST = 250;
   localparam int DIST_LIMIT   = 10;

   localparam int NUM_REGS   = 8;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS);

   localparam int REG_DESIRED    = 0;
   localparam int REG_MINIMUM    = 1;
   localparam int REG_SAFETY_GAP = 2;
   localparam int REG_GAIN_P     = 3;
   localparam int REG_GAIN_I     = 4;
   localparam int REG_GAIN_D     = 5;
   localparam int REG_RESUME     = 6;
   localparam int REG_OUT_MAX    = 7;

   localparam logic [VAL_W-1:0] CSR_RESET [NUM_REGS] = '{
      31'd1337983, 31'd79954, 31'd58982, 31'd6554,
      31'd6554, 31'd6554, 31'd262144, 31'd13107200
   };

   typedef enum logic [MODE_W-1:0] {
      MODE_STANDBY = 3'd0,
      MODE_RESUME  = 3'd1,
      MODE_CRUISE  = 3'd2,
      MODE_FOLLOW  = 3'd3,
      MODE_STOP    = 3'd4
   } mode_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_START,
      OP_GAP,
      OP_SQ1_START,
      OP_MARGIN,
      OP_MODE,
      OP_MUL_VV,
      OP_MUL_KT,
      OP_SQ2_START,
      OP_ERR,
      OP_MUL_HI,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_SUM,
      OP_PID,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic sqrt_busy;
      logic sqrt_done;
      logic pid_needed;
      logic rsp_free;
   } status_type;

endpackage

// ----- hdl/acps_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on acps_pkg.
`timescale 1ns / 1ps

module acps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [acps_pkg::NUM_W-1:0]  dividend,
   input  logic [acps_pkg::VAL_W-1:0]  divisor,
   output logic                        busy,
   output logic                        done,
   output logic [acps_pkg::NUM_W-1:0]  quotient
);
   import acps_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [VAL_W-1:0]     dsr_ff, dsr_in;
   logic [VAL_W:0]       shifted;
   logic [VAL_W:0]       diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/acps_sqrt.sv -----
// Bitwise integer square root, one root bit per cycle, rounds down.
// Depends on acps_pkg.
`timescale 1ns / 1ps

module acps_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [acps_pkg::RAD_W-1:0]  radicand,
   output logic                        busy,
   output logic                        done,
   output logic [acps_pkg::ROOT_W-1:0] root
);
   import acps_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] x_ff, x_in;
   logic [RAD_W-1:0] r_ff, r_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W-1:0] trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

// ----- hdl/acps_datapath.sv -----
// Datapath: configuration registers, controller state, shared multiplier,
// divider and square-root units, PID arithmetic and the result register.
// Depends on acps_pkg, acps_div and acps_sqrt.
`timescale 1ns / 1ps

module acps_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  acps_pkg::cmd_type                cmd,
   output acps_pkg::status_type             status,
   input  logic                             req_tvalid,
   input  logic [acps_pkg::TDATA_IN_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             csr_we,
   input  logic [acps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [acps_pkg::VAL_W-1:0]       csr_wdata,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [acps_pkg::TDATA_OUT_W-1:0] rsp_tdata
);
   import acps_pkg::*;

   logic [VAL_W-1:0] cfg_ff [NUM_REGS];

   logic [VAL_W-1:0]    speed_ff, speed_in;
   mode_type            mode_ff, mode_in;
   logic [VAL_W-1:0]    integ_ff, integ_in;
   logic [VAL_W-1:0]    prev_ff, prev_in;
   logic [VAL_W-1:0]    pid_ff, pid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TDATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [VAL_W-1:0]    gap_ff, gap_in;
   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [RAD_W-1:0]    vv_ff, vv_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W-1:0]    err_ff, err_in;
   logic signed [31:0]  deriv_ff, deriv_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // unit interfaces
   logic              div_busy, div_done, sqrt_busy, sqrt_done;
   logic [NUM_W-1:0]  quotient;
   logic [ROOT_W-1:0] root;
   logic              sqrt_start;
   logic [RAD_W-1:0]  radicand;

   logic [VAL_W-1:0] des, stg;
   logic             rsp_free;
   logic             pid_needed;

   assign des = cfg_ff[REG_DESIRED];
   assign stg = cfg_ff[REG_SAFETY_GAP];

   acps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (NUM_W'(dist_ff) << (2 * FRAC_BITS)),
      .divisor  (speed_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sqrt_start = (cmd.op == OP_SQ1_START) || (cmd.op == OP_SQ2_START);
   assign radicand   = (cmd.op == OP_SQ1_START) ? (RAD_W'(gap_ff) << FRAC_BITS)
                                                : vv_ff + prod_ff[RAD_W-1:0];

   acps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (root)
   );

   // mode decision terms
   logic [VAL_W:0] lim;
   logic gap_lt_lim, gap_gt_lim, gap_gt_stg, gap_zero;
   logic v_eq_des, v_lt_des, v_gt_min, d_gt, d_lt;

   assign lim        = {1'b0, stg} + (VAL_W+1)'(margin_ff);
   assign gap_lt_lim = {1'b0, gap_ff} < lim;
   assign gap_gt_lim = {1'b0, gap_ff} > lim;
   assign gap_gt_stg = gap_ff > stg;
   assign gap_zero   = gap_ff == '0;
   assign v_eq_des   = speed_ff == des;
   assign v_lt_des   = speed_ff < des;
   assign v_gt_min   = speed_ff > cfg_ff[REG_MINIMUM];
   assign d_gt       = dist_ff > DIST_W'(DIST_LIMIT);
   assign d_lt       = dist_ff < DIST_W'(DIST_LIMIT);

   assign pid_needed = (mode_ff == MODE_STANDBY) || (mode_ff == MODE_STOP) ||
                       (mode_ff == MODE_FOLLOW);

   // |margin + safety gap - gap|
   logic signed [T_W-1:0] t_val;
   logic [MUL_A_W-1:0]    t_abs;
   assign t_val = $signed(T_W'(margin_ff)) + $signed(T_W'(stg)) - $signed(T_W'(gap_ff));
   assign t_abs = t_val[T_W-1] ? MUL_A_W'(-t_val) : MUL_A_W'(t_val);

   // shared multiplier
   logic [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_res;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_VV: begin
            mul_a = MUL_A_W'(speed_ff);
            mul_b = $signed(MUL_B_W'(speed_ff));
         end
         OP_MUL_KT: begin
            mul_a = t_abs;
            mul_b = (mode_ff == MODE_FOLLOW) ? MUL_B_W'(K27_Q) : MUL_B_W'(K2_Q);
         end
         OP_MUL_HI: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(HUNDREDTH_Q);
         end
         OP_MUL_P: begin
            mul_a = MUL_A_W'(cfg_ff[REG_GAIN_P]);
            mul_b = $signed(MUL_B_W'(err_ff));
         end
         OP_MUL_I: begin
            mul_a = MUL_A_W'(cfg_ff[REG_GAIN_I]);
            mul_b = $signed(MUL_B_W'(integ_ff));
         end
         OP_MUL_D: begin
            mul_a = MUL_A_W'(cfg_ff[REG_GAIN_D]);
            mul_b = MUL_B_W'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = $signed({1'b0, mul_a}) * mul_b;

   // arithmetic helpers
   logic [63:0]             quo_wide;
   logic [ROOT_W:0]         m_sum;
   logic signed [ROOT_W:0]  e_diff;
   logic signed [31:0]      d_diff;
   logic signed [38:0]      d_x100;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [PROD_W-1:0] prod_tz;
   logic [VAL_W+1:0]        i_sum;
   logic signed [ACC_W-1:0] omax_ext;
   logic signed [NV_W-1:0]  v_ext, nv;
   logic [VAL_W-1:0]        v_new;

   assign quo_wide = 64'(quotient);
   assign m_sum    = {1'b0, root} + (ROOT_W+1)'(HALF_Q);
   assign e_diff   = $signed({1'b0, root}) - $signed((ROOT_W+1)'(speed_ff));
   assign d_diff   = $signed({1'b0, err_ff}) - $signed({1'b0, prev_ff});
   assign d_x100   = ($signed(39'(d_diff)) <<< 6) + ($signed(39'(d_diff)) <<< 5) +
                     ($signed(39'(d_diff)) <<< 2);
   assign prod_sh  = prod_ff >>> FRAC_BITS;
   // truncate toward zero for negative products
   assign prod_tz  = $signed(prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(ONE_Q - 1) : PROD_W'(0)))
                     >>> FRAC_BITS;
   assign i_sum    = (VAL_W+2)'(integ_ff) + (VAL_W+2)'(prod_sh[VAL_W:0]);
   assign omax_ext = $signed(ACC_W'(cfg_ff[REG_OUT_MAX]));
   assign v_ext    = $signed(NV_W'(speed_ff));

   always_comb begin
      case (mode_ff)
         MODE_STANDBY: nv = v_ext + $signed(NV_W'(pid_ff));
         MODE_FOLLOW:  nv = v_ext - $signed(NV_W'(pid_ff));
         MODE_RESUME:  nv = v_ext + $signed(NV_W'(cfg_ff[REG_RESUME]));
         MODE_STOP:    nv = '0;
         default:      nv = v_ext;
      endcase
      if (nv > $signed(NV_W'(des))) begin
         v_new = des;
      end else if (nv < 0) begin
         v_new = '0;
      end else begin
         v_new = nv[VAL_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      speed_in     = speed_ff;
      mode_in      = mode_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      pid_in       = pid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      dist_in      = dist_ff;
      gap_in       = gap_ff;
      margin_in    = margin_ff;
      vv_in        = vv_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      deriv_in     = deriv_ff;
      acc_in       = acc_ff;
      case (cmd.op)
         OP_LOAD: begin
            if (req_tvalid) begin
               dist_in = req_tuser ? DIST_W'(NO_ECHO_DIST) : req_tdata[DIST_W-1:0];
            end
         end
         OP_GAP: begin
            if (div_done) begin
               if (speed_ff == '0) begin
                  gap_in = '0;
               end else if (quo_wide > 64'(INT32_MAX)) begin
                  gap_in = '1;
               end else begin
                  gap_in = quo_wide[VAL_W-1:0];
               end
            end
         end
         OP_MARGIN: begin
            if (sqrt_done) begin
               margin_in = (m_sum > (ROOT_W+1)'(TEN_Q)) ? MARGIN_W'(TEN_Q)
                                                       : m_sum[MARGIN_W-1:0];
            end
         end
         OP_MODE: begin
            case (mode_ff)
               MODE_STANDBY: begin
                  if (v_gt_min) mode_in = MODE_RESUME;
               end
               MODE_RESUME: begin
                  if (gap_lt_lim && !gap_zero) mode_in = MODE_FOLLOW;
                  else if (v_eq_des && gap_gt_stg) mode_in = MODE_CRUISE;
                  else if (gap_zero) mode_in = MODE_STOP;
               end
               MODE_CRUISE: begin
                  if (gap_gt_lim && v_eq_des) mode_in = MODE_CRUISE;
                  else if (gap_lt_lim) mode_in = MODE_FOLLOW;
                  else if (v_lt_des && gap_gt_lim) mode_in = MODE_RESUME;
               end
               MODE_FOLLOW: begin
                  if (gap_gt_lim && d_gt) mode_in = MODE_RESUME;
                  else if (!gap_gt_stg && d_lt) mode_in = MODE_STOP;
               end
               default: begin
                  if (gap_gt_stg || d_gt) mode_in = MODE_RESUME;
               end
            endcase
         end
         OP_MUL_VV: prod_in = mul_res;
         OP_MUL_KT: begin
            vv_in   = prod_ff[RAD_W-1:0];
            prod_in = mul_res;
         end
         OP_ERR: begin
            if (sqrt_done) begin
               err_in = e_diff[VAL_W] ? VAL_W'(INT32_MAX) : e_diff[VAL_W-1:0];
            end
         end
         OP_MUL_HI: begin
            prod_in = mul_res;
            if (d_x100 > 39'(INT32_MAX)) deriv_in = 32'(INT32_MAX);
            else if (d_x100 < 39'(INT32_MIN)) deriv_in = 32'(INT32_MIN);
            else deriv_in = d_x100[31:0];
         end
         OP_MUL_P: begin
            prod_in = mul_res;
            // integrate only above one hundredth
            if (64'(err_ff) > 64'(HUNDREDTH_Q)) begin
               integ_in = (i_sum > (VAL_W+2)'(INT32_MAX)) ? VAL_W'(INT32_MAX)
                                                        : i_sum[VAL_W-1:0];
            end
         end
         OP_MUL_I: begin
            prod_in = mul_res;
            acc_in  = prod_sh[ACC_W-1:0];
         end
         OP_MUL_D: begin
            prod_in = mul_res;
            acc_in  = acc_ff + prod_sh[ACC_W-1:0];
         end
         OP_SUM: acc_in = acc_ff + prod_tz[ACC_W-1:0];
         OP_PID: begin
            if (acc_ff < 0) pid_in = '0;
            else if (acc_ff > omax_ext) pid_in = cfg_ff[REG_OUT_MAX];
            else pid_in = acc_ff[VAL_W-1:0];
            prev_in = err_ff;
         end
         OP_FINISH: begin
            if (rsp_free) begin
               speed_in     = v_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, pid_ff, MARGIN_OUT_W'(margin_ff), gap_ff,
                               mode_ff, v_new};
            end
         end
         default: begin
            speed_in = speed_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= CSR_RESET[i];
         end
         speed_ff     <= VAL_W'(ONE_Q);
         mode_ff      <= MODE_STANDBY;
         integ_ff     <= '0;
         prev_ff      <= '0;
         pid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cfg_ff[csr_addr] <= csr_wdata;
         end
         speed_ff     <= speed_in;
         mode_ff      <= mode_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         pid_ff       <= pid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      dist_ff     <= dist_in;
      gap_ff      <= gap_in;
      margin_ff   <= margin_in;
      vv_ff       <= vv_in;
      prod_ff     <= prod_in;
      err_ff      <= err_in;
      deriv_ff    <= deriv_in;
      acc_ff      <= acc_in;
   end

   assign status.div_busy   = div_busy;
   assign status.div_done   = div_done;
   assign status.sqrt_busy  = sqrt_busy;
   assign status.sqrt_done  = sqrt_done;
   assign status.pid_needed = pid_needed;
   assign status.rsp_free   = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/acps_ctrl.sv -----
// Controller state machine: sequences the datapath through one step.
// Depends on acps_pkg.
`timescale 1ns / 1ps

module acps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  acps_pkg::status_type status,
   output acps_pkg::cmd_type    cmd
);
   import acps_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_DIV      = 17'h00002,
      ST_DIV_WAIT = 17'h00004,
      ST_SQ1      = 17'h00008,
      ST_SQ1_WAIT = 17'h00010,
      ST_MODE     = 17'h00020,
      ST_MUL_VV   = 17'h00040,
      ST_MUL_KT   = 17'h00080,
      ST_SQ2      = 17'h00100,
      ST_SQ2_WAIT = 17'h00200,
      ST_MUL_HI   = 17'h00400,
      ST_MUL_P    = 17'h00800,
      ST_MUL_I    = 17'h01000,
      ST_MUL_D    = 17'h02000,
      ST_SUM      = 17'h04000,
      ST_PID      = 17'h08000,
      ST_FINISH   = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.op = OP_LOAD;
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.op = OP_GAP;
            if (status.div_done) state_in = ST_SQ1;
         end
         ST_SQ1: begin
            cmd.op   = OP_SQ1_START;
            state_in = ST_SQ1_WAIT;
         end
         ST_SQ1_WAIT: begin
            cmd.op = OP_MARGIN;
            if (status.sqrt_done) state_in = ST_MODE;
         end
         ST_MODE: begin
            cmd.op   = OP_MODE;
            state_in = ST_MUL_VV;
         end
         ST_MUL_VV: begin
            // skip the PID in resume and cruise
            cmd.op   = OP_MUL_VV;
            state_in = status.pid_needed ? ST_MUL_KT : ST_FINISH;
         end
         ST_MUL_KT: begin
            cmd.op   = OP_MUL_KT;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.op   = OP_SQ2_START;
            state_in = ST_SQ2_WAIT;
         end
         ST_SQ2_WAIT: begin
            cmd.op = OP_ERR;
            if (status.sqrt_done) state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.op   = OP_MUL_I;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.op   = OP_MUL_D;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_PID;
         end
         ST_PID: begin
            cmd.op   = OP_PID;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op = OP_FINISH;
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// ----- hdl/adaptive_cruise_pid_step_unit.sv -----
// Adaptive cruise control step with stop and go: top level.
// Depends on acps_pkg, acps_ctrl and acps_datapath.
`timescale 1ns / 1ps

// One item is one control tick: a sonar distance (or a no-echo flag meaning
// 250) goes in, and one result item comes out with the new speed, the drive
// mode, the time gap, the safety margin and the PID output, the values in
// unsigned Q15.16 and the margin in Q4.16. The unit works on one item at a
// time; a step runs the 40-step restoring divider for the gap and the 32-step
// square-root unit, used once for the margin and, when the PID runs (standby,
// follow, stop), once for the braking term; resume and cruise skip the PID.
// The multiplies share one multiplier whose product is registered. The next
// item is taken while a finished result waits in the output register. The
// user must write registers through the csr port only while no item is in
// flight; the block itself does not enforce this.

module adaptive_cruise_pid_step_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [acps_pkg::TDATA_IN_W-1:0]  req_tdata,  // [7:0] front_distance
   input  logic                             req_tuser,  // [0] no_echo
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [30:0] speed_now, [33:31] drive_mode, [64:34] gap_seconds,
   // [84:65] safety_margin, [115:85] pid_drive, [119:116] zero
   output logic [acps_pkg::TDATA_OUT_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [acps_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [acps_pkg::VAL_W-1:0]       csr_wdata
);
   import acps_pkg::*;

   cmd_type    cmd;
   status_type status;

   acps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   acps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in flight");

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!status.div_busy && !status.sqrt_busy))
      else $error("arithmetic unit busy while ready for an item");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH && status.rsp_free) |=> rsp_tvalid)
      else $error("finished item not presented");
`endif

endmodule

// ----- tb/adaptive_cruise_pid_step_unit_test.sv -----
// Self-checking bench for the adaptive cruise PID step unit.
// Drives sonar ticks over a stream port, predicts each result in 64-bit integer
// arithmetic and compares it field by field. Depends on acps_pkg and the DUT.
`timescale 1ns / 1ps

module adaptive_cruise_pid_step_unit_test;
   import acps_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [VAL_W-1:0]        pid_drive;
      logic [MARGIN_OUT_W-1:0] margin;
      logic [VAL_W-1:0]        gap;
      logic [MODE_W-1:0]       mode;
      logic [VAL_W-1:0]        speed;
   } tick_result_type;

   typedef struct {
      logic [7:0] distance;
      logic       no_echo;
      logic       has_exp;
      logic [VAL_W-1:0] exp_speed;
      mode_type   exp_mode;
   } tick_row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0;
   logic [TDATA_IN_W-1:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [VAL_W-1:0] csr_wdata = '0;

   adaptive_cruise_pid_step_unit dut (.*);

   // predictor state
   longint regs_m [NUM_REGS];
   longint speed_m, integ_m, prev_err_m, pid_m;
   mode_type mode_m;

   tick_result_type expected_q [$];
   int   speed_check_q [$];   // -1 none, else typed-in speed check
   int   mode_check_q [$];
   int   errors = 0, mismatches = 0, results_seen = 0, items_sent = 0;
   int   cycles = 0;
   int   send_idle_pct = 12, recv_idle_pct = 58;
   bit   hold_rsp = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("adaptive_cruise_pid_step_unit_test: done, errors");
         $finish;
      end
   end

   function automatic longint sat32(longint x);
      if (x > INT32_MAX) return INT32_MAX;
      if (x < INT32_MIN) return INT32_MIN;
      return x;
   endfunction

   function automatic longint root_floor(longint unsigned x);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint fxmul(longint a, longint b);
      return (a * b) / ONE_Q;
   endfunction

   function automatic longint pid_update(longint diff);
      longint err, deriv, sum;
      err = sat32(diff);
      if (err > HUNDREDTH_Q) integ_m = sat32(integ_m + fxmul(err, HUNDREDTH_Q));
      deriv = sat32((err - prev_err_m) * 100);
      sum = sat32(fxmul(regs_m[REG_GAIN_P], err) + fxmul(regs_m[REG_GAIN_I], integ_m)
                  + fxmul(regs_m[REG_GAIN_D], deriv));
      if (sum > regs_m[REG_OUT_MAX]) sum = regs_m[REG_OUT_MAX];
      if (sum < 0) sum = 0;
      prev_err_m = err;
      pid_m = sum;
      return sum;
   endfunction

   function automatic longint brake_term(longint v, longint k, longint margin, longint gap);
      longint t;
      longint unsigned inner;
      t = margin + regs_m[REG_SAFETY_GAP] - gap;
      if (t < 0) t = -t;
      inner = longint'(v * v) + longint'(k * t);
      return root_floor(inner) - v;
   endfunction

   function automatic tick_result_type predict_tick(logic [7:0] dist_in, logic no_echo);
      longint d, v, des, stg, gap, margin, lim;
      tick_result_type r;
      d = no_echo ? NO_ECHO_DIST : longint'(dist_in);
      v = speed_m; des = regs_m[REG_DESIRED]; stg = regs_m[REG_SAFETY_GAP];
      gap = (v > 0) ? sat32((d << (2 * FRAC_BITS)) / v) : 0;
      margin = HALF_Q + root_floor(gap << FRAC_BITS);
      if (margin > TEN_Q) margin = TEN_Q;
      lim = margin + stg;
      case (mode_m)
         MODE_STANDBY: if (v > regs_m[REG_MINIMUM]) mode_m = MODE_RESUME;
         MODE_RESUME: begin
            if (gap < lim && gap != 0) mode_m = MODE_FOLLOW;
            else if (v == des && gap > stg) mode_m = MODE_CRUISE;
            else if (gap == 0) mode_m = MODE_STOP;
         end
         MODE_CRUISE: begin
            if (gap > lim && v == des) mode_m = MODE_CRUISE;
            else if (gap < lim) mode_m = MODE_FOLLOW;
            else if (v < des && gap > lim) mode_m = MODE_RESUME;
         end
         MODE_FOLLOW: begin
            if (gap > lim && d > DIST_LIMIT) mode_m = MODE_RESUME;
            else if (gap <= stg && d < DIST_LIMIT) mode_m = MODE_STOP;
         end
         default: if (gap > stg || d > DIST_LIMIT) mode_m = MODE_RESUME;
      endcase
      if (mode_m != MODE_FOLLOW) begin
         if (mode_m != MODE_CRUISE && mode_m != MODE_RESUME)
            v += pid_update(brake_term(v, K2_Q, margin, gap));
         if (mode_m == MODE_RESUME) v += regs_m[REG_RESUME];
         if (mode_m == MODE_STOP) v = 0;
      end else v -= pid_update(brake_term(v, K27_Q, margin, gap));
      if (v > des) v = des;
      if (v < 0) v = 0;
      speed_m = v;
      r.speed = v[VAL_W-1:0];
      r.mode = mode_m;
      r.gap = gap[VAL_W-1:0];
      r.margin = margin[MARGIN_OUT_W-1:0];
      r.pid_drive = pid_m[VAL_W-1:0];
      return r;
   endfunction

   task automatic write_reg(int idx, logic [VAL_W-1:0] val);
      @(negedge clock);
      csr_we <= 1; csr_addr <= idx[CSR_ADDR_W-1:0]; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      regs_m[idx] = longint'(val);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // offer one tick, hold until accepted; predict at acceptance
   task automatic send_tick(logic [7:0] dist_in, logic no_echo, int chk_speed, int chk_mode);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1; req_tdata <= dist_in; req_tuser <= no_echo;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(predict_tick(dist_in, no_echo));
      speed_check_q.push_back(chk_speed);
      mode_check_q.push_back(chk_mode);
      items_sent++;
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // receiver ready pattern
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      tick_result_type got, want;
      int cs, cm;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tick_result_type'(rsp_tdata[115:0]);
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected item %h", got);
         end else begin
            want = expected_q.pop_front();
            cs = speed_check_q.pop_front();
            cm = mode_check_q.pop_front();
            if (got !== want || rsp_tdata[119:116] !== 4'd0
                || (cs >= 0 && got.speed !== cs[VAL_W-1:0])
                || (cm >= 0 && got.mode !== cm[MODE_W-1:0])) begin
               errors++;
               if (mismatches++ < 10)
                  $display("item %0d mismatch: exp spd %0d mode %0d gap %0d mar %0d pid %0d / got spd %0d mode %0d gap %0d mar %0d pid %0d",
                     results_seen, want.speed, want.mode, want.gap, want.margin, want.pid_drive,
                     got.speed, got.mode, got.gap, got.margin, got.pid_drive);
            end
         end
      end
   end

   task automatic random_phase(int n);
      int run;
      logic [7:0] d;
      for (int i = 0; i < n; i++) begin
         // mostly runs of similar distances so modes settle and change
         if ($urandom_range(9) < 7) begin
            d = 8'($urandom_range(255));
            run = $urandom_range(8, 1);
            for (int k = 0; k < run; k++)
               send_tick(8'(d + $urandom_range(6) - 3), ($urandom_range(19) == 0), -1, -1);
            i += run - 1;
         end else send_tick(8'($urandom), 1'($urandom), -1, -1);
      end
   endtask

   task automatic random_regs(bit extreme);
      for (int r = 0; r < NUM_REGS; r++)
         if (extreme) write_reg(r, ($urandom_range(1)) ? 31'h7FFFFFFF : 31'd0);
         else case (r)
            REG_DESIRED: write_reg(r, 31'($urandom_range(4000000, 1000)));
            REG_MINIMUM: write_reg(r, 31'($urandom_range(200000)));
            REG_SAFETY_GAP: write_reg(r, 31'($urandom_range(600000)));
            REG_OUT_MAX: write_reg(r, 31'($urandom_range(30000000)));
            REG_RESUME: write_reg(r, 31'($urandom_range(600000)));
            default: write_reg(r, 31'($urandom_range(40000)));
         endcase
   endtask

   tick_row_type rows [$];

   initial begin
      for (int r = 0; r < NUM_REGS; r++) regs_m[r] = longint'(CSR_RESET[r]);
      speed_m = ONE_Q; mode_m = MODE_STANDBY; integ_m = 0; prev_err_m = 0; pid_m = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: 1.0 from reset is below the minimum, so the first tick stays
      // in standby and the PID lifts the speed
      rows.push_back('{8'd0,   1'b0, 1'b1, 31'd694016, MODE_STANDBY});
      rows.push_back('{8'd255, 1'b0, 1'b0, 31'd0, MODE_STANDBY});
      rows.push_back('{8'd0,   1'b1, 1'b0, 31'd0, MODE_STANDBY});
      for (int i = 0; i < 6; i++) rows.push_back('{8'd250, 1'b1, 1'b0, 31'd0, MODE_STANDBY});
      for (int i = 0; i < 5; i++) rows.push_back('{8'd5,   1'b0, 1'b0, 31'd0, MODE_STANDBY});
      for (int i = 0; i < 4; i++) rows.push_back('{8'd0,   1'b0, 1'b0, 31'd0, MODE_STANDBY});
      rows.push_back('{8'd11,  1'b0, 1'b0, 31'd0, MODE_STANDBY});
      rows.push_back('{8'd10,  1'b0, 1'b0, 31'd0, MODE_STANDBY});
      rows.push_back('{8'd9,   1'b0, 1'b0, 31'd0, MODE_STANDBY});
      rows.push_back('{8'd128, 1'b1, 1'b0, 31'd0, MODE_STANDBY});
      foreach (rows[i])
         send_tick(rows[i].distance, rows[i].no_echo,
                   rows[i].has_exp ? int'(rows[i].exp_speed) : -1,
                   rows[i].has_exp ? int'(rows[i].exp_mode) : -1);

      // every register at its max then zero, with ticks between
      wait_drained();
      for (int r = 0; r < NUM_REGS; r++) write_reg(r, 31'h7FFFFFFF);
      for (int i = 0; i < 8; i++) send_tick(8'($urandom), 1'($urandom), -1, -1);
      wait_drained();
      for (int r = 0; r < NUM_REGS; r++) write_reg(r, 31'd0);
      for (int i = 0; i < 4; i++) send_tick(8'($urandom), 1'($urandom), -1, -1);
      wait_drained();
      for (int r = 0; r < NUM_REGS; r++) write_reg(r, CSR_RESET[r]);

      random_phase(450);
      // fill up behind a stalled receiver
      hold_rsp = 1;
      fork
         begin repeat (600) @(negedge clock); hold_rsp = 0; end
         for (int i = 0; i < 6; i++) send_tick(8'($urandom), 1'b0, -1, -1);
      join
      wait_drained();
      random_regs(1);
      random_phase(60);
      wait_drained();
      random_regs(0);
      send_idle_pct = 58; recv_idle_pct = 12;
      random_phase(450);
      wait_drained();
      random_regs(0);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(450);

      wait_drained();
      $display("covered %0d ticks, %0d results, directed extremes, stall and register sweeps",
               items_sent, results_seen);
      if (errors == 0 && expected_q.size() == 0)
         $display("adaptive_cruise_pid_step_unit_test: done, clean");
      else begin
         $display("%0d mismatches, %0d left over", mismatches, expected_q.size());
         $display("adaptive_cruise_pid_step_unit_test: done, errors");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/acps_pkg.sv
hdl/acps_div.sv
hdl/acps_sqrt.sv
hdl/acps_datapath.sv
hdl/acps_ctrl.sv
hdl/adaptive_cruise_pid_step_unit.sv
tb/adaptive_cruise_pid_step_unit_test.sv
